### hdl/ptxq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptxq_pkg
// Shared types and constants for the persistent XOR trie: node layout,
// transaction payloads, controller states and datapath operations.
// ----------------------------------------------------------------------------
package ptxq_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int NODE_POOL   = 65535;
  localparam int HANDLE_W    = 16;
  localparam int STORE_DEPTH = 1 << HANDLE_W;
  localparam int POOL_LIMIT  = (NODE_POOL < STORE_DEPTH - 1) ? NODE_POOL : STORE_DEPTH - 1;
  localparam int BIT_IDX_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  // rank residue can grow by one count per level; keep a sign bit
  localparam int K_W         = HANDLE_W + $clog2(VALUE_BITS + 1) + 1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_MAX    = 2'd1,
    CMD_KTH    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] version_a;
    logic [15:0] version_b;
    logic [31:0] value;
    logic [15:0] rank;
  } req_t;

  typedef struct packed {
    logic [31:0] answer;
    logic [15:0] new_version;
    logic [15:0] element_count;
    logic        found;
    logic        pool_full;
  } rsp_t;

  typedef struct packed {
    logic [1:0][HANDLE_W-1:0] child;
    logic [HANDLE_W-1:0]      count;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS,
    ST_Q_ROOT,
    ST_Q_DEC,
    ST_Q_NODE,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FULL,
    OP_CLEAR,
    OP_INS_START,
    OP_INS_STEP,
    OP_Q_ROOT,
    OP_Q_TOTAL,
    OP_Q_DECIDE,
    OP_Q_LOAD
  } dp_op_t;

  typedef struct packed {
    cmd_t command;
    logic pool_ok;
    logic query_ok;
    logic dir_want;
    logic last_bit;
    logic leaf;
  } dp_status_t;

endpackage
`default_nettype wire

### hdl/ptxq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptxq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ptxq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output      logic [WIDTH-1:0]         rdata_a,
  output      logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

### hdl/ptxq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptxq_dp
// Datapath: node store, path-copy writer, query walker and result registers.
// ----------------------------------------------------------------------------
module ptxq_dp
  import ptxq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_op_t     op,
  input  wire req_t       request,
  output      dp_status_t status,
  output      rsp_t       response
);

  // store port signals
  logic                wr_en;
  logic [HANDLE_W-1:0] wr_addr;
  node_t               wr_node;
  logic [HANDLE_W-1:0] rd_addr_a, rd_addr_b;
  logic [NODE_W-1:0]   rdata_a, rdata_b;

  // registers
  cmd_t                   cmd_q;
  logic [HANDLE_W-1:0]    va_q, vb_q, rank_q;
  logic [VALUE_BITS-1:0]  val_q, ans_q;
  logic signed [K_W-1:0]  k_q;
  logic [BIT_IDX_W-1:0]   bit_idx;
  logic                   leaf_q;
  logic [HANDLE_W-1:0]    nodes_used, h_q;
  logic [HANDLE_W-1:0]    ra_addr_q, rb_addr_q;
  logic                   byp_q;
  node_t                  pure_q;
  node_t                  p_node, q_node;
  logic [HANDLE_W-1:0]    new_version, element_count;
  logic                   found, pool_full;

  // combinational
  node_t                  na, nb, nd, ins_node;
  logic                   cur, want, want_nx;
  logic signed [HANDLE_W:0] diff;
  logic signed [K_W-1:0]  diff_k;
  logic [HANDLE_W:0]      used_sum;
  logic                   query_ok, dir_want;

  ptxq_ram #(
    .WIDTH (NODE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_node),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    // handle 0 is the empty node and is never written
    na = (ra_addr_q == '0) ? node_t'('0) : node_t'(rdata_a);
    nb = (rb_addr_q == '0) ? node_t'('0) : node_t'(rdata_b);
    // a source equal to the node just written still reads its plain copy
    nd = byp_q ? pure_q : na;

    cur     = val_q[bit_idx];
    want    = ~cur;
    want_nx = ~val_q[bit_idx - BIT_IDX_W'(1)];

    ins_node       = nd;
    ins_node.count = nd.count + 1'b1;
    wr_node        = ins_node;
    if (!leaf_q) begin
      wr_node.child[cur] = h_q + 1'b1;
    end
    wr_en   = (op == OP_INS_STEP);
    wr_addr = h_q;

    diff   = $signed({1'b0, na.count}) - $signed({1'b0, nb.count});
    diff_k = {{(K_W - HANDLE_W - 1){diff[HANDLE_W]}}, diff};

    query_ok = (diff > 0) &&
               ((cmd_q == CMD_MAX) ||
                ((rank_q != '0) && ({1'b0, rank_q} <= $unsigned(diff))));
    dir_want = (cmd_q == CMD_MAX) ? (diff > 0) : (diff_k >= k_q);

    used_sum = {1'b0, nodes_used} + (HANDLE_W + 1)'(VALUE_BITS + 1);

    rd_addr_a = '0;
    rd_addr_b = '0;
    unique case (op) inside
      OP_INS_START: rd_addr_a = va_q;
      OP_INS_STEP:  rd_addr_a = nd.child[cur];
      OP_Q_ROOT: begin
        rd_addr_a = va_q;
        rd_addr_b = vb_q;
      end
      OP_Q_TOTAL, OP_Q_LOAD: begin
        rd_addr_a = na.child[want];
        rd_addr_b = nb.child[want];
      end
      OP_Q_DECIDE: begin
        if (dir_want) begin
          rd_addr_a = na.child[want_nx];
          rd_addr_b = nb.child[want_nx];
        end else begin
          rd_addr_a = p_node.child[cur];
          rd_addr_b = q_node.child[cur];
        end
      end
      default: begin
        rd_addr_a = '0;
        rd_addr_b = '0;
      end
    endcase

    status.command  = cmd_q;
    status.pool_ok  = (used_sum <= (HANDLE_W + 1)'(POOL_LIMIT));
    status.query_ok = query_ok;
    status.dir_want = dir_want;
    status.last_bit = (bit_idx == '0);
    status.leaf     = leaf_q;

    response.answer        = 32'(ans_q);
    response.new_version   = new_version;
    response.element_count = element_count;
    response.found         = found;
    response.pool_full     = pool_full;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used <= '0;
    end else if (op == OP_CLEAR) begin
      nodes_used <= '0;
    end else if (op == OP_INS_STEP && leaf_q) begin
      nodes_used <= h_q;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    ra_addr_q <= rd_addr_a;
    rb_addr_q <= rd_addr_b;
    byp_q     <= (op == OP_INS_STEP) && (rd_addr_a == h_q);
    pure_q    <= ins_node;

    case (op)
      OP_LOAD: begin
        cmd_q         <= request.command;
        va_q          <= request.version_a;
        vb_q          <= request.version_b;
        val_q         <= request.value[VALUE_BITS-1:0];
        rank_q        <= request.rank;
        k_q           <= {{(K_W - HANDLE_W){1'b0}}, request.rank};
        bit_idx       <= BIT_IDX_W'(VALUE_BITS - 1);
        leaf_q        <= 1'b0;
        ans_q         <= '0;
        new_version   <= '0;
        element_count <= '0;
        found         <= 1'b0;
        pool_full     <= 1'b0;
      end
      OP_FULL: pool_full <= 1'b1;
      OP_INS_START: begin
        h_q         <= nodes_used + 1'b1;
        new_version <= nodes_used + 1'b1;
      end
      OP_INS_STEP: begin
        h_q <= h_q + 1'b1;
        if (bit_idx == '0) begin
          leaf_q <= 1'b1;
        end else begin
          bit_idx <= bit_idx - 1'b1;
        end
      end
      OP_Q_TOTAL: begin
        p_node        <= na;
        q_node        <= nb;
        element_count <= diff[HANDLE_W-1:0];
      end
      OP_Q_DECIDE: begin
        ans_q[bit_idx] <= dir_want;
        if (dir_want) begin
          p_node <= na;
          q_node <= nb;
        end else if (cmd_q == CMD_KTH) begin
          k_q <= k_q - diff_k;
        end
        if (bit_idx == '0) begin
          found <= 1'b1;
        end else begin
          bit_idx <= bit_idx - 1'b1;
        end
      end
      OP_Q_LOAD: begin
        p_node <= na;
        q_node <= nb;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/ptxq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptxq_ctrl
// Controller: sequences insert, query and clear transactions over the
// datapath, one operation per cycle.
// ----------------------------------------------------------------------------
module ptxq_ctrl
  import ptxq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t status,
  output      dp_op_t     op,
  output      logic       busy,
  output      logic       done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (status.command) inside
          CMD_INSERT:       state_next = status.pool_ok ? ST_INS : ST_FINISH;
          CMD_MAX, CMD_KTH: state_next = ST_Q_ROOT;
          CMD_CLEAR:        state_next = ST_FINISH;
          default:          state_next = ST_FINISH;
        endcase
      end
      ST_INS:    if (status.leaf) state_next = ST_FINISH;
      ST_Q_ROOT: state_next = status.query_ok ? ST_Q_DEC : ST_FINISH;
      ST_Q_DEC: begin
        if (status.last_bit) begin
          state_next = ST_FINISH;
        end else if (!status.dir_want) begin
          state_next = ST_Q_NODE;
        end
      end
      ST_Q_NODE: state_next = ST_Q_DEC;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    op   = OP_NONE;
    busy = (state != ST_IDLE);
    done = (state == ST_FINISH);
    unique case (state)
      ST_IDLE: op = start ? OP_LOAD : OP_NONE;
      ST_DISPATCH: begin
        unique case (status.command) inside
          CMD_INSERT:       op = status.pool_ok ? OP_INS_START : OP_FULL;
          CMD_MAX, CMD_KTH: op = OP_Q_ROOT;
          CMD_CLEAR:        op = OP_CLEAR;
          default:          op = OP_NONE;
        endcase
      end
      ST_INS:    op = OP_INS_STEP;
      ST_Q_ROOT: op = OP_Q_TOTAL;
      ST_Q_DEC:  op = OP_Q_DECIDE;
      ST_Q_NODE: op = OP_Q_LOAD;
      default:   op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/persistent_binary_trie_xor_query.sv
`default_nettype none
// ----------------------------------------------------------------------------
// persistent_binary_trie_xor_query
// Persistent binary trie with path-copy insert, max-XOR and k-th largest XOR
// queries over the difference of two versions, and a pool clear.
// ----------------------------------------------------------------------------
// One transaction at a time: busy stays high through the result strobe.
// The receiver cannot stall: done is high for exactly one cycle.
// Reset: synchronous, active high; empties the pool, node contents are kept.
// ----------------------------------------------------------------------------
module persistent_binary_trie_xor_query
  import ptxq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output      logic busy,
  input  wire req_t request,
  output      logic done,
  output      rsp_t response
);

  // The controller walks one state per trie level:
  //   insert - one step per copied node; each step writes node h and reads
  //            the next source node, a one-deep bypass covering the case of a
  //            source equal to the node written just before.
  //   query  - reads the 'wanted' children of both versions, decides, and
  //            needs a second read only when the walk turns away from them.
  // Handle 0 is the empty node; reads of it are forced to zero, so the store
  // needs no clearing pass.

  dp_op_t     op;
  dp_status_t status;

  ptxq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy),
    .done   (done)
  );

  ptxq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .request  (request),
    .status   (status),
    .response (response)
  );

endmodule
`default_nettype wire
